FILE: hw/rtl/hmc_pkg.sv
package hmc_pkg;

  localparam int BUCKETS    = 256;
  localparam int WAYS       = 4;
  localparam int COUNT_BITS = 16;
  localparam int SLOTS      = BUCKETS * WAYS;
  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CFG_W      = 9;
  localparam int HASH_W     = 32;
  localparam int REM_W      = BKT_W + 1;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_SEARCH = 3'd1;
  localparam logic [2:0] OP_COUNT  = 3'd2;
  localparam logic [2:0] OP_CHECK  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic init_wr;     // clear one valid bit of the post-reset pass
    logic load;        // latch key, start hash/modulo
    logic mod_step;    // one modulo step
    logic probe_rd;    // read slot at probe way
    logic probe_cmp;   // compare registered read
    logic walk_rd;     // read slot at walk index
    logic walk_do;     // act on walked slot
    logic wr_new;      // write new entry at free way
    logic wr_total;    // bump total of found slot
    logic wr_match;    // bump matches of found slot
    logic way_inc;     // next probe way
    logic walk_inc;    // next walk index
    logic clr;         // reset probe/walk indexes and flags
  } hmc_cmd_t;

  typedef struct packed {
    logic init_last;
    logic mod_done;
    logic way_last;
    logic walk_last;
    logic found;
    logic free_seen;
    logic mismatch;
  } hmc_sts_t;

  function automatic logic [HASH_W-1:0] mix_key(input logic [HASH_W-1:0] k);
    logic [HASH_W-1:0] h;
    h = k ^ (k >> 20) ^ (k >> 12);
    h = h ^ (h >> 7) ^ (h >> 4);
    return h;
  endfunction

endpackage

FILE: hw/rtl/hmc_ctrl.sv
module hmc_ctrl import hmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [2:0] op,
  input  logic       out_tready,
  output logic       out_tvalid,
  output logic       hit_o,
  output logic       all_match_o,
  output logic       overflow_o,
  input  hmc_sts_t   sts,
  output hmc_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MOD, S_PRD, S_PCMP, S_ACT, S_WRD, S_WDO, S_OUT
  } state_t;

  state_t     state_r;
  logic [2:0] op_r;
  logic       hit_r, all_r, ovf_r;

  assign in_tready   = (state_r == S_IDLE);
  assign out_tvalid  = (state_r == S_OUT);
  assign hit_o       = hit_r;
  assign all_match_o = all_r;
  assign overflow_o  = ovf_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_INIT: cmd.init_wr = 1'b1;
      S_IDLE: begin
        cmd.load = in_tvalid;
        cmd.clr  = in_tvalid;
      end
      S_MOD:  cmd.mod_step = 1'b1;
      S_PRD:  cmd.probe_rd = 1'b1;
      S_PCMP: begin
        cmd.probe_cmp = 1'b1;
        cmd.way_inc   = 1'b1;
      end
      S_ACT: begin
        if (op_r == OP_INSERT) begin
          if (sts.found) cmd.wr_total = 1'b1;
          else if (sts.free_seen) cmd.wr_new = 1'b1;
        end else if (op_r == OP_COUNT && sts.found) begin
          cmd.wr_match = 1'b1;
        end
      end
      S_WRD:  cmd.walk_rd = 1'b1;
      S_WDO: begin
        cmd.walk_do  = 1'b1;
        cmd.walk_inc = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      op_r    <= '0;
      hit_r   <= 1'b0;
      all_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      case (state_r)
        S_INIT: if (sts.init_last) state_r <= S_IDLE;
        S_IDLE: if (in_tvalid) begin
          op_r <= op;
          hit_r <= 1'b0; all_r <= 1'b0; ovf_r <= 1'b0;
          if (op == OP_CHECK || op == OP_CLEAR) state_r <= S_WRD;
          else if (op == OP_INSERT || op == OP_SEARCH || op == OP_COUNT) state_r <= S_MOD;
          else state_r <= S_OUT;
        end
        S_MOD:  if (sts.mod_done) state_r <= S_PRD;
        S_PRD:  state_r <= S_PCMP;
        S_PCMP: state_r <= (sts.way_last) ? S_ACT : S_PRD;
        S_ACT: begin
          hit_r <= sts.found;
          ovf_r <= (op_r == OP_INSERT) && !sts.found && !sts.free_seen;
          state_r <= S_OUT;
        end
        S_WRD:  state_r <= S_WDO;
        S_WDO: if (sts.walk_last) begin
          all_r   <= (op_r == OP_CHECK) && !sts.mismatch;
          state_r <= S_OUT;
        end else begin
          state_r <= S_WRD;
        end
        S_OUT:  if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/hmc_dp.sv
module hmc_dp import hmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [HASH_W-1:0] key,
  input  logic [2:0]        op,
  input  logic [CFG_W-1:0]  bucket_count,
  input  hmc_cmd_t          cmd,
  output hmc_sts_t          sts
);

  localparam int STEPS = HASH_W;
  localparam int SC_W  = $clog2(STEPS + 1);

  // store
  logic                  valid_mem [SLOTS];
  logic [HASH_W-1:0]     key_mem   [SLOTS];
  logic [COUNT_BITS-1:0] total_mem [SLOTS];
  logic [COUNT_BITS-1:0] match_mem [SLOTS];

  logic [SLOT_W:0]       init_r;
  logic [HASH_W-1:0]     key_r, hash_r;
  logic [2:0]            op_r;
  logic [REM_W-1:0]      div_r, rem_r;
  logic [SC_W-1:0]       step_r;
  logic [WAY_W:0]        way_r;
  logic [SLOT_W:0]       walk_r;
  logic [SLOT_W-1:0]     rd_addr_r, hit_slot_r, free_slot_r;
  logic                  found_r, free_r, mis_r, rd_valid_r;
  logic [HASH_W-1:0]     rd_key_r;
  logic [COUNT_BITS-1:0] rd_total_r, rd_match_r;

  logic [REM_W:0]        rem_sh;
  logic [SLOT_W-1:0]     probe_addr;
  logic [REM_W-1:0]      div_nxt;

  always_comb begin
    if (bucket_count == '0) div_nxt = REM_W'(1);
    else if (bucket_count > CFG_W'(BUCKETS)) div_nxt = REM_W'(BUCKETS);
    else div_nxt = REM_W'(bucket_count);
  end

  assign rem_sh = {rem_r, hash_r[HASH_W-1]};
  assign probe_addr = SLOT_W'(rem_r[BKT_W-1:0]) * SLOT_W'(WAYS)
                    + SLOT_W'(way_r[WAY_W-1:0]);

  assign sts.init_last = (init_r == (SLOT_W+1)'(SLOTS - 1));
  assign sts.mod_done  = (step_r == SC_W'(STEPS));
  assign sts.way_last  = (way_r == (WAY_W+1)'(WAYS - 1));
  assign sts.walk_last = (walk_r == (SLOT_W+1)'(SLOTS - 1));
  assign sts.found     = found_r;
  assign sts.free_seen = free_r;
  // includes the slot being walked right now
  assign sts.mismatch  = mis_r | (rd_valid_r && rd_match_r != rd_total_r);

  // post-reset clearing pass over the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) init_r <= '0;
    else if (cmd.init_wr && !sts.init_last) init_r <= init_r + (SLOT_W+1)'(1);
  end

  // restoring remainder, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= key;
      hash_r <= mix_key(key);
      op_r   <= op;
      div_r  <= div_nxt;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.mod_step && step_r != SC_W'(STEPS)) begin
      hash_r <= hash_r << 1;
      step_r <= step_r + SC_W'(1);
      if (rem_sh >= {1'b0, div_r}) rem_r <= REM_W'(rem_sh - {1'b0, div_r});
      else rem_r <= rem_sh[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      way_r   <= '0;
      walk_r  <= '0;
      found_r <= 1'b0;
      free_r  <= 1'b0;
      mis_r   <= 1'b0;
    end else begin
      if (cmd.way_inc && !sts.way_last) way_r <= way_r + (WAY_W+1)'(1);
      if (cmd.walk_inc && !sts.walk_last) walk_r <= walk_r + (SLOT_W+1)'(1);
      if (cmd.probe_cmp) begin
        if (rd_valid_r && rd_key_r == key_r && !found_r) begin
          found_r <= 1'b1;
          hit_slot_r <= rd_addr_r;
        end
        if (!rd_valid_r && !free_r) begin
          free_r <= 1'b1;
          free_slot_r <= rd_addr_r;
        end
      end
      if (cmd.walk_do && rd_valid_r && rd_match_r != rd_total_r) mis_r <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (cmd.probe_rd || cmd.walk_rd) begin
      rd_addr_r  <= cmd.probe_rd ? probe_addr : walk_r[SLOT_W-1:0];
      rd_valid_r <= valid_mem[cmd.probe_rd ? probe_addr : walk_r[SLOT_W-1:0]];
      rd_key_r   <= key_mem[cmd.probe_rd ? probe_addr : walk_r[SLOT_W-1:0]];
      rd_total_r <= total_mem[cmd.probe_rd ? probe_addr : walk_r[SLOT_W-1:0]];
      rd_match_r <= match_mem[cmd.probe_rd ? probe_addr : walk_r[SLOT_W-1:0]];
    end
  end

  // found slot's counts, latched on its probe
  logic [COUNT_BITS-1:0] f_total_r, f_match_r;
  always_ff @(posedge clk) begin
    if (cmd.probe_cmp && rd_valid_r && rd_key_r == key_r && !found_r) begin
      f_total_r <= rd_total_r;
      f_match_r <= rd_match_r;
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      key_mem[free_slot_r]   <= key_r;
      total_mem[free_slot_r] <= COUNT_BITS'(1);
      match_mem[free_slot_r] <= '0;
    end else if (cmd.wr_total) begin
      total_mem[hit_slot_r] <= (f_total_r == COUNT_MAX) ? COUNT_MAX
                                                         : f_total_r + COUNT_BITS'(1);
    end else if (cmd.wr_match) begin
      match_mem[hit_slot_r] <= (f_match_r == COUNT_MAX) ? COUNT_MAX
                                                         : f_match_r + COUNT_BITS'(1);
    end else if (cmd.walk_do && op_r == OP_CLEAR && rd_valid_r) begin
      match_mem[rd_addr_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) valid_mem[init_r[SLOT_W-1:0]] <= 1'b0;
    else if (cmd.wr_new) valid_mem[free_slot_r] <= 1'b1;
  end

endmodule

FILE: hw/rtl/hashed_multiset_counter.sv
// Insert, search and counting search pass through accept, the modulo (32 steps and
//   the done check), a read and a compare for each probe way, one action and an output state.
// Check and clear walk the whole store of 1024 slots, with a read and an action for each slot.
// One item at a time; throughput is set by the bit-serial modulo and the single read port.
// Reset (synchronous, rst_n low) sets bucket_count to 256; then a pass over all 1024 slots
//   clears the valid bits, one slot a cycle, with in_tready low until it ends.
module hashed_multiset_counter import hmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] operation, [34:3] key, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] hit, [1] all_match, [2] overflow, rest zero
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata   // bucket_count
);

  logic [CFG_W-1:0] bucket_count_r;
  hmc_cmd_t cmd;
  hmc_sts_t sts;
  logic hit, all_match, overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= CFG_W'(256);
    else if (cfg_we) bucket_count_r <= cfg_wdata;
  end

  hmc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_tvalid, .in_tready,
    .op          (in_tdata[2:0]),
    .out_tready, .out_tvalid,
    .hit_o       (hit),
    .all_match_o (all_match),
    .overflow_o  (overflow),
    .sts, .cmd
  );

  hmc_dp u_dp (
    .clk, .rst_n,
    .key          (in_tdata[34:3]),
    .op           (in_tdata[2:0]),
    .bucket_count (bucket_count_r),
    .cmd, .sts
  );

  assign out_tdata = {5'b0, overflow, all_match, hit};

endmodule
